>>> hw/rtl/wfpid_pkg.sv
// ----------------------------------------------------------------------------
// Wall-follow PID wheel drive: shared package
// Field widths, register codes, reset values and the reciprocal used to
// divide the control sum by one hundred.
// ----------------------------------------------------------------------------
package wfpid_pkg;

   // Field and register widths
   localparam int TARGET_W    = 12;
   localparam int DEADBAND_W  = 12;
   localparam int GAIN_W      = 8;
   localparam int LEVEL_W     = 13;
   localparam int ERR_W       = 13;
   localparam int ADJ_W       = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // Combined gains: kc = p + i + d, kq = i - d
   localparam int GSUM_W  = GAIN_W + 2;
   localparam int GSKEW_W = GAIN_W + 1;

   // Control sum: |kc*e| + |kq*prev| < 2**22
   localparam int SUM_W = 23;
   localparam int MAG_W = SUM_W - 1;

   // Divide by a constant through a rounded-up reciprocal, exact below 2**MAG_W
   localparam int DIVISOR     = 100;
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_W     = 23;
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'((2 ** RECIP_SHIFT + DIVISOR - 1) / DIVISOR);

   // Saturation bounds of the error
   localparam logic [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
   localparam logic [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

   // Reset values
   localparam logic [TARGET_W-1:0]   TARGET_RESET   = TARGET_W'(900);
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(50);
   localparam logic [GAIN_W-1:0]     GAIN_P_RESET   = GAIN_W'(55);
   localparam logic [GAIN_W-1:0]     GAIN_I_RESET   = GAIN_W'(10);
   localparam logic [GAIN_W-1:0]     GAIN_D_RESET   = GAIN_W'(25);
   localparam logic [LEVEL_W-1:0]    PWM_HIGH_RESET = LEVEL_W'(6000);
   localparam logic [LEVEL_W-1:0]    PWM_LOW_RESET  = LEVEL_W'(1200);
   localparam logic [LEVEL_W-1:0]    LEVEL_RESET    = LEVEL_W'(6000);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_AUTO_MODE   = 3'd0,
      REG_TARGET_MM   = 3'd1,
      REG_DEADBAND_MM = 3'd2,
      REG_GAIN_P      = 3'd3,
      REG_GAIN_I      = 3'd4,
      REG_GAIN_D      = 3'd5,
      REG_PWM_HIGH    = 3'd6,
      REG_PWM_LOW     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                  auto_mode;
      logic [TARGET_W-1:0]   target_mm;
      logic [DEADBAND_W-1:0] deadband_mm;
      logic [GAIN_W-1:0]     gain_p;
      logic [GAIN_W-1:0]     gain_i;
      logic [GAIN_W-1:0]     gain_d;
      logic [LEVEL_W-1:0]    pwm_high;
      logic [LEVEL_W-1:0]    pwm_low;
   } cfg_type;

   typedef struct packed {
      logic signed [ADJ_W-1:0] adjust;
      logic                    active;
   } adj_item_type;

endpackage

>>> hw/rtl/wfpid_csr.sv
// ----------------------------------------------------------------------------
// Wall-follow PID wheel drive: configuration registers
// Write-only register bank, one register per index, masked to its width.
// ----------------------------------------------------------------------------
module wfpid_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [wfpid_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wfpid_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output wfpid_pkg::cfg_type                  cfg
);

   wfpid_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_mode   <= 1'b0;
         cfg_ff.target_mm   <= wfpid_pkg::TARGET_RESET;
         cfg_ff.deadband_mm <= wfpid_pkg::DEADBAND_RESET;
         cfg_ff.gain_p      <= wfpid_pkg::GAIN_P_RESET;
         cfg_ff.gain_i      <= wfpid_pkg::GAIN_I_RESET;
         cfg_ff.gain_d      <= wfpid_pkg::GAIN_D_RESET;
         cfg_ff.pwm_high    <= wfpid_pkg::PWM_HIGH_RESET;
         cfg_ff.pwm_low     <= wfpid_pkg::PWM_LOW_RESET;
      end else if (csr_write_enable) begin
         unique case (wfpid_pkg::csr_index_type'(csr_index))
            wfpid_pkg::REG_AUTO_MODE: begin
               cfg_ff.auto_mode <= csr_write_data[0];
            end
            wfpid_pkg::REG_TARGET_MM: begin
               cfg_ff.target_mm <= csr_write_data[wfpid_pkg::TARGET_W-1:0];
            end
            wfpid_pkg::REG_DEADBAND_MM: begin
               cfg_ff.deadband_mm <= csr_write_data[wfpid_pkg::DEADBAND_W-1:0];
            end
            wfpid_pkg::REG_GAIN_P: begin
               cfg_ff.gain_p <= csr_write_data[wfpid_pkg::GAIN_W-1:0];
            end
            wfpid_pkg::REG_GAIN_I: begin
               cfg_ff.gain_i <= csr_write_data[wfpid_pkg::GAIN_W-1:0];
            end
            wfpid_pkg::REG_GAIN_D: begin
               cfg_ff.gain_d <= csr_write_data[wfpid_pkg::GAIN_W-1:0];
            end
            wfpid_pkg::REG_PWM_HIGH: begin
               cfg_ff.pwm_high <= csr_write_data[wfpid_pkg::LEVEL_W-1:0];
            end
            wfpid_pkg::REG_PWM_LOW: begin
               cfg_ff.pwm_low <= csr_write_data[wfpid_pkg::LEVEL_W-1:0];
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/wfpid_law.sv
// ----------------------------------------------------------------------------
// Wall-follow PID wheel drive: control law pipeline
// Input register, error and deadband, gain products, sum with the stored
// previous-error term, and truncating divide by one hundred.
// ----------------------------------------------------------------------------
module wfpid_law #(
   parameter int DISTANCE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wfpid_pkg::cfg_type            cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [DISTANCE_BITS-1:0]      in_distance,
   output logic                          out_valid,
   input  logic                          out_ready,
   output wfpid_pkg::adj_item_type       out_item
);

   localparam int MAX_W = (DISTANCE_BITS > wfpid_pkg::TARGET_W) ?
                          DISTANCE_BITS : wfpid_pkg::TARGET_W;
   localparam int RAW_W = MAX_W + 1;
   localparam int ERR_W = wfpid_pkg::ERR_W;
   localparam int SUM_W = wfpid_pkg::SUM_W;
   localparam int MAG_W = wfpid_pkg::MAG_W;

   // Stage enables: a stage loads when it is empty or its item moves on
   logic en0, en1, en2, en3;

   // Stage 0: input register
   logic                     v0_ff;
   logic [DISTANCE_BITS-1:0] dist0_ff;

   // Stage 1: error and current-error product
   logic                    v1_ff, act1_ff;
   logic [ERR_W-1:0]        err1_ff, err1_in;
   logic signed [SUM_W-1:0] pc1_ff, pc1_in;

   // Stage 2: sign and magnitude of the control sum
   logic             v2_ff, act2_ff, neg2_ff, neg2_in;
   logic [MAG_W-1:0] mag2_ff, mag2_in;

   // Stage 3: adjust value
   logic                               v3_ff, act3_ff;
   logic signed [wfpid_pkg::ADJ_W-1:0] adj3_ff, adj3_in;

   // Previous error and its gain product
   logic [ERR_W-1:0]        prev_err_ff, prev_err_in;
   logic signed [SUM_W-1:0] q_ff, q_in;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign en0      = !v0_ff || en1;
   assign in_ready = en0;

   // Error, saturation, deadband, kc * e
   logic [RAW_W-1:0]           raw;
   logic [RAW_W-ERR_W:0]       raw_top;
   logic [ERR_W-1:0]           sat, sat_mag;
   logic [wfpid_pkg::GSUM_W-1:0] kc;
   logic signed [SUM_W-1:0]    kc_ext, e_ext;

   always_comb begin
      raw = {{(RAW_W-wfpid_pkg::TARGET_W){1'b0}}, cfg.target_mm}
          - {{(RAW_W-DISTANCE_BITS){1'b0}}, dist0_ff};
      raw_top = raw[RAW_W-1:ERR_W-1];
      if ((&raw_top) || !(|raw_top)) begin
         sat = raw[ERR_W-1:0];
      end else if (raw[RAW_W-1]) begin
         sat = wfpid_pkg::ERR_MIN;
      end else begin
         sat = wfpid_pkg::ERR_MAX;
      end
      sat_mag = sat[ERR_W-1] ? (~sat + 1'b1) : sat;
      // zero inside the deadband, and always when control is off
      if (!cfg.auto_mode || (sat_mag <= {1'b0, cfg.deadband_mm})) begin
         err1_in = '0;
      end else begin
         err1_in = sat;
      end
      kc = {2'b00, cfg.gain_p} + {2'b00, cfg.gain_i} + {2'b00, cfg.gain_d};
      kc_ext = {{(SUM_W-wfpid_pkg::GSUM_W){1'b0}}, kc};
      e_ext  = {{(SUM_W-ERR_W){err1_in[ERR_W-1]}}, err1_in};
      pc1_in = kc_ext * e_ext;
   end

   // kq * prev, tracked so it always matches the stored previous error
   logic signed [wfpid_pkg::GSKEW_W-1:0] kq;
   logic signed [SUM_W-1:0]              kq_ext, prev_ext;

   always_comb begin
      kq = {1'b0, cfg.gain_i} - {1'b0, cfg.gain_d};
      if (v1_ff && en2 && act1_ff) begin
         prev_err_in = err1_ff;
      end else begin
         prev_err_in = prev_err_ff;
      end
      kq_ext   = {{(SUM_W-wfpid_pkg::GSKEW_W){kq[wfpid_pkg::GSKEW_W-1]}}, kq};
      prev_ext = {{(SUM_W-ERR_W){prev_err_in[ERR_W-1]}}, prev_err_in};
      q_in     = kq_ext * prev_ext;
   end

   // Sum and magnitude
   logic signed [SUM_W-1:0] sum, sum_neg;

   always_comb begin
      sum     = pc1_ff + q_ff;
      sum_neg = ~sum + 1'b1;
      neg2_in = act1_ff && sum[SUM_W-1];
      if (!act1_ff) begin
         mag2_in = '0;
      end else if (sum[SUM_W-1]) begin
         mag2_in = sum_neg[MAG_W-1:0];
      end else begin
         mag2_in = sum[MAG_W-1:0];
      end
   end

   // Truncating divide by one hundred on the magnitude, then restore the sign
   logic [wfpid_pkg::PROD_W-1:0] prod;
   logic [wfpid_pkg::QUO_W-1:0]  quo;
   logic [wfpid_pkg::ADJ_W-1:0]  quo_ext;

   always_comb begin
      prod    = wfpid_pkg::PROD_W'(mag2_ff) * wfpid_pkg::PROD_W'(wfpid_pkg::RECIP_MULT);
      quo     = prod[wfpid_pkg::PROD_W-1:wfpid_pkg::RECIP_SHIFT];
      quo_ext = {{(wfpid_pkg::ADJ_W-wfpid_pkg::QUO_W){1'b0}}, quo};
      adj3_in = neg2_ff ? (~quo_ext + 1'b1) : quo_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         prev_err_ff <= '0;
         q_ff        <= '0;
      end else begin
         prev_err_ff <= prev_err_in;
         q_ff        <= q_in;
         if (en0) begin
            v0_ff <= in_valid;
         end
         if (en1) begin
            v1_ff <= v0_ff;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en0 && in_valid) begin
         dist0_ff <= in_distance;
      end
      if (en1 && v0_ff) begin
         act1_ff <= cfg.auto_mode;
         err1_ff <= err1_in;
         pc1_ff  <= pc1_in;
      end
      if (en2 && v1_ff) begin
         act2_ff <= act1_ff;
         neg2_ff <= neg2_in;
         mag2_ff <= mag2_in;
      end
      if (en3 && v2_ff) begin
         act3_ff <= act2_ff;
         adj3_ff <= adj3_in;
      end
   end

   assign out_valid       = v3_ff;
   assign out_item.adjust = adj3_ff;
   assign out_item.active = act3_ff;

   a_prev_hold: assert property (@(posedge clock) disable iff (reset)
      !(v1_ff && en2 && act1_ff) |=> $stable(prev_err_ff))
      else $error("previous error moved without an active item leaving stage 1");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !act2_ff) |-> (mag2_ff == '0 && !neg2_ff))
      else $error("inactive item carries a nonzero control sum");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !out_ready) |=> (v3_ff && $stable(adj3_ff) && $stable(act3_ff)))
      else $error("stalled adjust item changed");

endmodule

>>> hw/rtl/wfpid_drive.sv
// ----------------------------------------------------------------------------
// Wall-follow PID wheel drive: wheel level update and result register
// Applies the adjust value to the wheel levels, clamps them, and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
module wfpid_drive (
   input  logic                                    clock,
   input  logic                                    reset,
   input  wfpid_pkg::cfg_type                      cfg,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  wfpid_pkg::adj_item_type                 in_item,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [wfpid_pkg::LEVEL_W-1:0]           rsp_right_drive,
   output logic [wfpid_pkg::LEVEL_W-1:0]           rsp_left_drive,
   output logic signed [wfpid_pkg::ADJ_W-1:0]      rsp_adjust_value,
   output logic                                    rsp_active
);

   localparam int LEVEL_W = wfpid_pkg::LEVEL_W;
   localparam int ADJ_W   = wfpid_pkg::ADJ_W;
   localparam int LV_W    = ADJ_W + 1;

   logic                     rsp_valid_ff;
   logic [LEVEL_W-1:0]       right_level_ff, right_level_in;
   logic [LEVEL_W-1:0]       left_level_ff, left_level_in;
   logic signed [ADJ_W-1:0]  adjust_ff;
   logic                     active_ff;
   logic                     load;

   function automatic logic [LEVEL_W-1:0] clamp_level(
      input logic signed [LV_W-1:0] v,
      input logic [LEVEL_W-1:0]     hi,
      input logic [LEVEL_W-1:0]     lo
   );
      logic signed [LV_W-1:0] t, hi_ext, lo_ext;
      hi_ext = {{(LV_W-LEVEL_W){1'b0}}, hi};
      lo_ext = {{(LV_W-LEVEL_W){1'b0}}, lo};
      t = v;
      // low limit last, so it wins when the limits cross
      if (t > hi_ext) begin
         t = hi_ext;
      end
      if (t < lo_ext) begin
         t = lo_ext;
      end
      return t[LEVEL_W-1:0];
   endfunction

   logic signed [LV_W-1:0] adj_ext, right_ext, left_ext, high_ext;
   logic signed [LV_W-1:0] right_raw, left_raw;

   always_comb begin
      adj_ext   = {in_item.adjust[ADJ_W-1], in_item.adjust};
      right_ext = {{(LV_W-LEVEL_W){1'b0}}, right_level_ff};
      left_ext  = {{(LV_W-LEVEL_W){1'b0}}, left_level_ff};
      high_ext  = {{(LV_W-LEVEL_W){1'b0}}, cfg.pwm_high};
      priority if (in_item.adjust[ADJ_W-1]) begin
         left_raw  = high_ext;
         right_raw = right_ext + adj_ext;
      end else if (in_item.adjust != '0) begin
         left_raw  = left_ext - adj_ext;
         right_raw = high_ext;
      end else begin
         left_raw  = left_ext;
         right_raw = right_ext;
      end
      right_level_in = clamp_level(right_raw, cfg.pwm_high, cfg.pwm_low);
      left_level_in  = clamp_level(left_raw, cfg.pwm_high, cfg.pwm_low);
   end

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         right_level_ff <= wfpid_pkg::LEVEL_RESET;
         left_level_ff  <= wfpid_pkg::LEVEL_RESET;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         // hold the levels when control is off
         if (in_item.active) begin
            right_level_ff <= right_level_in;
            left_level_ff  <= left_level_in;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         adjust_ff <= in_item.adjust;
         active_ff <= in_item.active;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_right_drive  = right_level_ff;
   assign rsp_left_drive   = left_level_ff;
   assign rsp_adjust_value = adjust_ff;
   assign rsp_active       = active_ff;

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      (load && in_item.active) |=>
         ((right_level_ff <= cfg.pwm_high || right_level_ff == cfg.pwm_low) &&
          (left_level_ff <= cfg.pwm_high || left_level_ff == cfg.pwm_low)))
      else $error("wheel level outside the clamp limits after an update");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (load && !in_item.active) |=>
         ($stable(right_level_ff) && $stable(left_level_ff)))
      else $error("wheel level changed on an inactive item");

   a_reload: assert property (@(posedge clock) disable iff (reset)
      (load && in_item.active && in_item.adjust[ADJ_W-1] &&
       cfg.pwm_high >= cfg.pwm_low) |=> (left_level_ff == cfg.pwm_high))
      else $error("left wheel not reloaded on a negative adjust");

endmodule

>>> hw/rtl/wall_follow_pid_wheel_drive_core.sv
// ----------------------------------------------------------------------------
// Wall-follow PID wheel drive core
// PID wall follower with deadband that steers two wheel PWM levels.
// ----------------------------------------------------------------------------
// Takes one right-wall distance item per cycle unless a waiting result stalls
// it, and returns one result item per item through the input register, error
// and gain product, control sum, divide by one hundred and wheel update. The
// previous-error product and the wheel levels are the only feedback and each
// closes within one stage. A waiting result does not block the pipeline until
// all stages are full. The user must write configuration registers through
// the csr port only while no item is in flight; the block does not enforce it.
module wall_follow_pid_wheel_drive_core #(
   parameter int DISTANCE_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [wfpid_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wfpid_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [DISTANCE_BITS-1:0]                req_distance_right_mm,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [wfpid_pkg::LEVEL_W-1:0]           rsp_right_drive,
   output logic [wfpid_pkg::LEVEL_W-1:0]           rsp_left_drive,
   output logic signed [wfpid_pkg::ADJ_W-1:0]      rsp_adjust_value,
   output logic                                    rsp_active
);

   wfpid_pkg::cfg_type      cfg;
   wfpid_pkg::adj_item_type adj_item;
   logic                    adj_valid;
   logic                    adj_ready;

   wfpid_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wfpid_law #(
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_law (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_distance (req_distance_right_mm),
      .out_valid   (adj_valid),
      .out_ready   (adj_ready),
      .out_item    (adj_item)
   );

   wfpid_drive u_drive (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_valid         (adj_valid),
      .in_ready         (adj_ready),
      .in_item          (adj_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_right_drive  (rsp_right_drive),
      .rsp_left_drive   (rsp_left_drive),
      .rsp_adjust_value (rsp_adjust_value),
      .rsp_active       (rsp_active)
   );

endmodule
